// ----- rtl/assert_macros.svh -----
// Assertion macros for the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define BDSI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the cycle after it.
`define BDSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bdsi_pkg.sv -----
// Types and constants of the bounded deque with sorted insert.
`default_nettype none

package bdsi_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [CNT_BITS-1:0]         cnt_t;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_INSERT     = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHR,
        OP_SHL,
        OP_DROP_BACK,
        OP_INSERT
    } op_t;

    typedef struct packed {
        op_t   op;
        logic  use_cmp;
        word_t value;
    } cell_ctl_t;

    typedef struct packed {
        logic  valid;
        word_t data;
    } link_t;

endpackage

`default_nettype wire

// ----- rtl/bounded_deque_sorted_insert_core.sv -----
// Top level: bounded deque with sorted insert built as a row of cells.
// The result is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the result side takes each result.
// The whole cell row shifts, inserts or drops its back entry as the request is accepted;
// a new request waits only while a result is pending and the result side does not take it.
// Reset clears the count, the valid bits and the result flag; cell data is not reset.
`default_nettype none
`include "assert_macros.svh"

module bounded_deque_sorted_insert_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [2:0]            cmd,
    input  wire logic signed [31:0]    value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [31:0]         popped,
    output logic [1:0]                 status,
    output logic [4:0]                 entries,
    output logic signed [31:0]         first_value,
    output logic signed [31:0]         last_value,
    output logic                       is_empty
);

    localparam int D = bdsi_pkg::DEPTH;

    bdsi_pkg::link_t      link   [D];
    logic                 found  [D+1];
    logic [D-1:0]         valid_vec;
    bdsi_pkg::link_t      end_link;
    bdsi_pkg::cell_ctl_t  ctl;

    bdsi_pkg::cnt_t       fill_reg;
    bdsi_pkg::cnt_t       fill_next;
    logic                 out_valid_reg;
    bdsi_pkg::word_t      popped_reg;
    bdsi_pkg::word_t      popped_next;
    bdsi_pkg::status_t    status_reg;
    bdsi_pkg::status_t    status_next;
    bdsi_pkg::word_t      last_word;
    logic                 in_fire;
    logic                 full;
    logic                 empty;
    bdsi_pkg::cmd_t       cmd_c;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign full     = fill_reg == bdsi_pkg::cnt_t'(D);
    assign empty    = fill_reg == '0;
    assign cmd_c    = bdsi_pkg::cmd_t'(cmd);
    assign end_link = '{valid: 1'b0, data: '0};
    assign found[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < D; gi++)
        begin : g_cell
            bdsi_pkg::link_t left_l;
            bdsi_pkg::link_t right_l;
            if (gi == 0)
            begin : g_first
                assign left_l = '{valid: 1'b1, data: value};
            end
            else
            begin : g_mid
                assign left_l = link[gi-1];
            end
            if (gi == D - 1)
            begin : g_last
                assign right_l = end_link;
            end
            else
            begin : g_inner
                assign right_l = link[gi+1];
            end
            bdsi_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .left      (left_l),
                .right     (right_l),
                .found_in  (found[gi]),
                .found_out (found[gi+1]),
                .self      (link[gi])
            );
            assign valid_vec[gi] = link[gi].valid;
        end
    endgenerate

    // back entry: the valid cell whose right neighbor is empty
    always_comb
    begin
        last_word = '0;
        for (int i = 0; i < D; i++)
        begin
            if (link[i].valid && (i == D - 1 || !valid_vec[(i + 1) % D]))
            begin
                last_word = last_word | link[i].data;
            end
        end
    end

    always_comb
    begin
        ctl         = '{op: bdsi_pkg::OP_HOLD, use_cmp: 1'b0, value: value};
        fill_next   = fill_reg;
        popped_next = '0;
        status_next = bdsi_pkg::ST_OK;
        if (in_fire)
        begin
            unique case (cmd_c)
                bdsi_pkg::CMD_PUSH_FRONT,
                bdsi_pkg::CMD_PUSH_BACK,
                bdsi_pkg::CMD_INSERT:
                begin
                    if (full)
                    begin
                        status_next = bdsi_pkg::ST_FULL;
                    end
                    else
                    begin
                        fill_next = fill_reg + bdsi_pkg::cnt_t'(1);
                        if (cmd_c == bdsi_pkg::CMD_PUSH_FRONT)
                        begin
                            ctl.op = bdsi_pkg::OP_SHR;
                        end
                        else
                        begin
                            ctl.op      = bdsi_pkg::OP_INSERT;
                            ctl.use_cmp = cmd_c == bdsi_pkg::CMD_INSERT;
                        end
                    end
                end
                bdsi_pkg::CMD_POP_FRONT,
                bdsi_pkg::CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = bdsi_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        fill_next = fill_reg - bdsi_pkg::cnt_t'(1);
                        if (cmd_c == bdsi_pkg::CMD_POP_FRONT)
                        begin
                            ctl.op      = bdsi_pkg::OP_SHL;
                            popped_next = link[0].data;
                        end
                        else
                        begin
                            ctl.op      = bdsi_pkg::OP_DROP_BACK;
                            popped_next = last_word;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign popped      = popped_reg;
    assign status      = status_reg;
    assign entries     = fill_reg;
    assign first_value = link[0].valid ? link[0].data : '0;
    assign last_value  = last_word;
    assign is_empty    = empty;

    `BDSI_ASSERT(a_fill_matches_cells, $countones(valid_vec) == int'(fill_reg),
        "count and valid cells disagree")
    `BDSI_ASSERT(a_cells_packed,
        ((({1'b0, valid_vec} + (D+1)'(1)) & {1'b0, valid_vec}) == '0),
        "valid cells not packed at front")
    `BDSI_ASSERT_NEXT(a_full_flagged,
        in_fire && full && (cmd_c == bdsi_pkg::CMD_PUSH_FRONT
            || cmd_c == bdsi_pkg::CMD_PUSH_BACK || cmd_c == bdsi_pkg::CMD_INSERT),
        status_reg == bdsi_pkg::ST_FULL && fill_reg == bdsi_pkg::cnt_t'(D),
        "push into full store not flagged")
    `BDSI_ASSERT_NEXT(a_empty_pop,
        in_fire && empty && (cmd_c == bdsi_pkg::CMD_POP_FRONT
            || cmd_c == bdsi_pkg::CMD_POP_BACK),
        status_reg == bdsi_pkg::ST_EMPTY && popped_reg == '0,
        "pop on empty store not flagged")

endmodule

`default_nettype wire

// ----- rtl/bdsi_cell.sv -----
// One storage cell of the deque row: holds a word and its valid bit.
`default_nettype none

module bdsi_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bdsi_pkg::cell_ctl_t ctl,
    input  wire bdsi_pkg::link_t   left,
    input  wire bdsi_pkg::link_t   right,
    input  wire logic              found_in,
    output logic                   found_out,
    output bdsi_pkg::link_t        self
);

    logic               valid_reg;
    logic               valid_next;
    bdsi_pkg::word_t    data_reg;
    bdsi_pkg::word_t    data_next;
    logic               ge;

    assign ge        = data_reg >= ctl.value;
    assign found_out = found_in | !valid_reg | (ctl.use_cmp & ge);
    assign self      = '{valid: valid_reg, data: data_reg};

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        unique case (ctl.op)
            bdsi_pkg::OP_HOLD:
            begin
            end
            bdsi_pkg::OP_SHR:
            begin
                valid_next = left.valid;
                data_next  = left.data;
            end
            bdsi_pkg::OP_SHL:
            begin
                valid_next = right.valid;
                data_next  = right.data;
            end
            bdsi_pkg::OP_DROP_BACK:
            begin
                valid_next = valid_reg & right.valid;
            end
            bdsi_pkg::OP_INSERT:
            begin
                if (found_in)
                begin
                    valid_next = left.valid;
                    data_next  = left.data;
                end
                else if (found_out)
                begin
                    valid_next = 1'b1;
                    data_next  = ctl.value;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ----- tb/sv/bounded_deque_sorted_insert_check.sv -----
// Checker for the sorted-insert deque: mirrors the store, predicts each reply, compares.
module bounded_deque_sorted_insert_check
    import bdsi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [2:0] cmd,
    input  word_t      value,
    input  logic       out_valid,
    input  logic       out_ready,
    input  word_t      popped,
    input  logic [1:0] status,
    input  logic [4:0] entries,
    input  word_t      first_value,
    input  word_t      last_value,
    input  logic       is_empty,
    output int         outstanding,
    output int         fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        word_t   popped;
        status_t status;
        cnt_t    entries;
        word_t   front;
        word_t   back;
        logic    empty;
    } reply_t;

    word_t  shadow_deque [$];
    reply_t replies_due [$];
    reply_t got;
    reply_t want;
    int     errs = 0;

    assign fail_count = errs;

    function automatic reply_t deque_apply(input logic [2:0] op, input word_t v);
        reply_t r;
        int     pos;
        r = '0;
        case (op)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT:
            begin
                if (shadow_deque.size() >= DEPTH)
                    r.status = ST_FULL;
                else if (op == CMD_PUSH_FRONT)
                    shadow_deque.push_front(v);
                else if (op == CMD_PUSH_BACK)
                    shadow_deque.push_back(v);
                else
                begin
                    pos = 0;
                    while (pos < shadow_deque.size() && shadow_deque[pos] < v)
                        pos++;
                    shadow_deque.insert(pos, v);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (shadow_deque.size() == 0)
                    r.status = ST_EMPTY;
                else if (op == CMD_POP_FRONT)
                    r.popped = shadow_deque.pop_front();
                else
                    r.popped = shadow_deque.pop_back();
            end
            default:
                ;
        endcase
        r.entries = cnt_t'(shadow_deque.size());
        r.empty   = (shadow_deque.size() == 0);
        if (!r.empty)
        begin
            r.front = shadow_deque[0];
            r.back  = shadow_deque[$];
        end
        return r;
    endfunction

    function automatic string reply_text(input reply_t r);
        return $sformatf("popped=%0d status=%0d entries=%0d first=%0d last=%0d empty=%0b",
                         r.popped, r.status, r.entries, r.front, r.back, r.empty);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_deque.delete();
            replies_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{popped, status_t'(status), entries, first_value, last_value, is_empty};
                if (replies_due.size() == 0)
                begin
                    if (errs < 10)
                        $display("%t: reply with no request pending: %s", $realtime,
                                 reply_text(got));
                    errs++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got !== want)
                    begin
                        if (errs < 10)
                            $display("%t: reply mismatch\n  expected %s\n  actual   %s",
                                     $realtime, reply_text(want), reply_text(got));
                        errs++;
                    end
                end
            end
            if (in_valid && in_ready)
                replies_due.push_back(deque_apply(cmd, value));
            outstanding <= replies_due.size();
        end
    end

endmodule

// ----- tb/sv/bounded_deque_sorted_insert_core_tb.sv -----
// Testbench top for the sorted-insert deque: clock, reset, request stimulus and verdict.
module bounded_deque_sorted_insert_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bdsi_pkg::*;

    localparam int    CMD_CODES = 8;
    localparam word_t WORD_MAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN  = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_SORTED, MODE_MIXED} mix_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [2:0] cmd       = '0;
    word_t      value     = '0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    word_t      popped;
    logic [1:0] status;
    logic [4:0] entries;
    word_t      first_value;
    word_t      last_value;
    logic       is_empty;
    int         outstanding;
    int         fail_count;

    int gap_pct   = 0;
    int stall_pct = 0;
    int sent      = 0;

    bounded_deque_sorted_insert_core dut (.*);

    bounded_deque_sorted_insert_check check (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // valid is left high after acceptance; the next call either keeps it or drops it
    task automatic send_req(input logic [2:0] c, input word_t v);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (c <= CMD_INSERT)
            sent++;
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic word_t pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return word_t'(int'($urandom_range(16)) - 8);
        if (r < 30)
        begin
            case ($urandom_range(5))
                0:       return WORD_MIN;
                1:       return WORD_MAX;
                2:       return '0;
                3:       return '1;
                4:       return WORD_MIN + 1;
                default: return WORD_MAX - 1;
            endcase
        end
        return word_t'($urandom);
    endfunction

    function automatic logic [2:0] pick_cmd(input mix_t m);
        int r;
        bit grow;
        r = $urandom_range(99);
        if (r < 4)
            return 3'(int'(CMD_INSERT) + int'($urandom_range(CMD_CODES - 1 - CMD_INSERT, 1)));
        case (m)
            MODE_GROW:   grow = (r < 72);
            MODE_SHRINK: grow = (r < 30);
            MODE_SORTED: grow = (r < 85);
            default:     grow = (r < 52);
        endcase
        if (grow)
        begin
            if (m == MODE_SORTED)
                return CMD_INSERT;
            case ($urandom_range(2))
                0:       return CMD_PUSH_FRONT;
                1:       return CMD_PUSH_BACK;
                default: return CMD_INSERT;
            endcase
        end
        return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    endfunction

    initial
    begin
        int   gap_tab [4]   = '{0, 53, 0, 35};
        int   stall_tab [4] = '{0, 0, 53, 35};
        int   goal;
        int   len;
        mix_t mode;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, unused codes, extremes, ties, insert past the back, unsorted insert
        send_req(CMD_POP_FRONT, WORD_MAX);
        send_req(CMD_POP_BACK, WORD_MIN);
        for (int c = int'(CMD_INSERT) + 1; c < CMD_CODES; c++)
            send_req(3'(c), pick_value());
        send_req(CMD_PUSH_BACK, 100);
        send_req(CMD_PUSH_FRONT, WORD_MIN);
        send_req(CMD_INSERT, 0);
        send_req(CMD_INSERT, 200);
        send_req(CMD_INSERT, WORD_MIN);
        send_req(CMD_PUSH_BACK, WORD_MAX);
        send_req(CMD_PUSH_FRONT, -1);
        send_req(CMD_INSERT, 50);
        repeat (DEPTH - 8) send_req(CMD_PUSH_BACK, word_t'($urandom));
        // full store
        send_req(CMD_PUSH_FRONT, WORD_MAX);
        send_req(CMD_PUSH_BACK, WORD_MIN);
        send_req(CMD_INSERT, 0);
        send_req(CMD_POP_BACK, '0);
        send_req(CMD_POP_FRONT, '1);
        hold_until_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            gap_pct   = gap_tab[ph];
            stall_pct = stall_tab[ph];
            goal      = sent + 355;
            while (sent < goal)
            begin
                mode = mix_t'($urandom_range(3));
                len  = $urandom_range(60, 8);
                // sorted runs start from an empty store
                if (mode == MODE_SORTED)
                    repeat (DEPTH) send_req(CMD_POP_FRONT, pick_value());
                repeat (len) send_req(pick_cmd(mode), pick_value());
            end
            hold_until_drained();
        end

        repeat (4) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("bounded_deque_sorted_insert_core test passed");
        else
            $display("bounded_deque_sorted_insert_core test failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("bounded_deque_sorted_insert_core test failed");
        $finish;
    end

endmodule
